/* hdl/art_pkg.sv */
// ----------------------------------------------------------------------------
// art_pkg - shared types and codes of the aging redirect table
// Request and result payloads, the table entry and the chain control group.
// ----------------------------------------------------------------------------
package art_pkg;

    // request kinds
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_SWEEP  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_REDIRECT_MINUTES   = 2'd0;
    localparam logic [1:0] CFG_RELAX_STEP_MINUTES = 2'd1;

    localparam logic [9:0] REDIRECT_MINUTES_RESET   = 10'd60;
    localparam logic [5:0] RELAX_STEP_MINUTES_RESET = 6'd10;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] volume_id;
        logic [31:0] target_addr;
        logic [30:0] now_seconds;
    } t_req;

    typedef struct packed {
        logic        found;
        logic [31:0] found_addr;
        logic [4:0]  dropped_count;
        logic [4:0]  entries_used;
    } t_result;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] target;
        logic [30:0] stamp;
    } t_entry;

    typedef struct packed {
        logic shift;  // every cell but the tail takes its newer neighbor
        logic load;   // the addressed cell takes the load data
    } t_chain_ctl;

endpackage

/* hdl/art_cell.sv */
// ----------------------------------------------------------------------------
// art_cell - one table entry
// Holds, takes its neighbor's entry on a shift, or takes broadcast load data.
// ----------------------------------------------------------------------------
module art_cell (
    input  logic                i_clk,
    input  art_pkg::t_chain_ctl i_ctl,
    input  logic                i_load_sel,
    input  art_pkg::t_entry     i_next,
    input  art_pkg::t_entry     i_load_data,
    output art_pkg::t_entry     o_entry
);
    import art_pkg::*;

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load && i_load_sel) begin
            r_entry <= i_load_data;
        end else if (i_ctl.shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;

endmodule

/* hdl/art_chain.sv */
// ----------------------------------------------------------------------------
// art_chain - row of entry cells
// Cell 0 holds the oldest entry and is the head of the row; a shift moves
// every entry one cell toward the head.
// ----------------------------------------------------------------------------
module art_chain #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                           i_clk,
    input  art_pkg::t_chain_ctl            i_ctl,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_load_idx,
    input  art_pkg::t_entry                i_load_data,
    output art_pkg::t_entry                o_head
);
    import art_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);

    t_entry w_entry [TABLE_DEPTH];

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        t_entry w_next;
        // the tail cell holds its own value on a shift
        if (g == TABLE_DEPTH - 1) begin : g_tail
            assign w_next = w_entry[g];
        end else begin : g_body
            assign w_next = w_entry[g + 1];
        end
        art_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (i_ctl),
            .i_load_sel  (i_load_idx == IW'(g)),
            .i_next      (w_next),
            .i_load_data (i_load_data),
            .o_entry     (w_entry[g])
        );
    end

    assign o_head = w_entry[0];

endmodule

/* hdl/aging_redirect_table.sv */
// ----------------------------------------------------------------------------
// aging_redirect_table - insertion-ordered redirect table with age-out
// Entries live in a row of cells, oldest at the head. Sweeps, evictions and
// lookups rotate the row through the head cell one entry per cycle.
// ----------------------------------------------------------------------------
//
//  channel   direction  transfer when           payload
//  in        input      i_in_valid & !o_in_stall  t_req: req_type, id, addr, now
//  out       output     o_out_valid & !i_out_stall t_result: found, addr, counts
//  cfg       input      i_cfg_we                i_cfg_index, i_cfg_data
//
//  Per request: a lookup makes one pass over the entries, a sweep fixes its
//  cutoff and makes one pass, and neither passes over an empty table. An
//  insert into a non-full table makes no pass; one into a full table repeats
//  cutoff and pass, lowering the horizon by the relax step, until an entry drops.
//  Reset empties the table and loads the register defaults.
//  A request is taken only while the controller is idle; a finished result
//  waits in the output register while the next request is taken.
// ----------------------------------------------------------------------------
module aging_redirect_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [9:0]       i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  art_pkg::t_req    i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output art_pkg::t_result o_out_data
);
    import art_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = $clog2(TABLE_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_CUT    = 4'b0010,
        S_PASS   = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    function automatic logic [4:0] sat5(input logic [CW-1:0] v);
        logic [CW+4:0] w;
        w = {5'b0, v};
        return (w > (CW + 5)'(31)) ? 5'd31 : w[4:0];
    endfunction

    t_state              r_state, n_state;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [CW-1:0]       r_left, n_left;
    logic [CW-1:0]       r_drop, n_drop;
    logic signed [11:0]  r_horizon, n_horizon;
    logic signed [32:0]  r_cutoff, n_cutoff;
    logic                r_flush, n_flush;
    logic                r_found, n_found;
    logic [31:0]         r_faddr, n_faddr;
    t_req                r_req, n_req;
    logic                r_out_valid, n_out_valid;
    t_result             r_out_data, n_out_data;
    logic [9:0]          r_redirect;
    logic [5:0]          r_relax;

    t_chain_ctl          w_ctl;
    logic [IW-1:0]       w_load_idx;
    t_entry              w_load_data;
    t_entry              w_head;
    logic [5:0]          w_step;
    logic [15:0]         w_span;
    logic [CW-1:0]       w_cnt_m1;
    logic                w_stay;
    logic                w_is_lookup;

    art_chain #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_chain (
        .i_clk       (i_clk),
        .i_ctl       (w_ctl),
        .i_load_idx  (w_load_idx),
        .i_load_data (w_load_data),
        .o_head      (w_head)
    );

    assign w_step      = (r_relax == 6'd0) ? 6'd1 : r_relax;
    assign w_span      = {6'b0, r_horizon[9:0]} * 16'd60;
    assign w_cnt_m1    = r_cnt - CW'(1);
    assign w_is_lookup = (r_req.req_type == REQ_LOOKUP);
    assign w_stay      = w_is_lookup ||
                         (!r_flush && ($signed({2'b0, w_head.stamp}) > r_cutoff));

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_left      = r_left;
        n_drop      = r_drop;
        n_horizon   = r_horizon;
        n_cutoff    = r_cutoff;
        n_flush     = r_flush;
        n_found     = r_found;
        n_faddr     = r_faddr;
        n_req       = r_req;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        w_ctl       = '0;
        w_load_idx  = w_cnt_m1[IW-1:0];
        w_load_data = w_head;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req     = i_in_data;
                    n_found   = 1'b0;
                    n_faddr   = 32'd0;
                    n_drop    = '0;
                    n_left    = r_cnt;
                    n_horizon = $signed({2'b0, r_redirect});
                    case (i_in_data.req_type)
                        REQ_INSERT: begin
                            n_state = (r_cnt >= CW'(TABLE_DEPTH)) ? S_CUT : S_FINISH;
                        end
                        REQ_LOOKUP: begin
                            n_state = (r_cnt != '0) ? S_PASS : S_FINISH;
                        end
                        REQ_SWEEP: begin
                            n_state = (r_cnt != '0) ? S_CUT : S_FINISH;
                        end
                        default: begin
                            n_state = S_FINISH;
                        end
                    endcase
                end
            end
            S_CUT: begin
                // fix the cutoff for one pass over the table
                n_cutoff = $signed({2'b0, r_req.now_seconds}) - $signed({17'b0, w_span});
                n_flush  = r_horizon[11];
                n_left   = r_cnt;
                n_state  = S_PASS;
            end
            S_PASS: begin
                // pop the head, push it back at the tail if it survives
                w_ctl.shift = 1'b1;
                w_ctl.load  = w_stay;
                if (!w_stay) begin
                    n_cnt  = w_cnt_m1;
                    n_drop = r_drop + CW'(1);
                end
                if (w_is_lookup && (w_head.id == r_req.volume_id)) begin
                    n_found = 1'b1;
                    n_faddr = w_head.target;
                end
                n_left = r_left - CW'(1);
                if (r_left == CW'(1)) begin
                    if ((r_req.req_type == REQ_INSERT) && (n_cnt == CW'(TABLE_DEPTH))) begin
                        n_horizon = r_horizon - $signed({6'b0, w_step});
                        n_state   = S_CUT;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    if (r_req.req_type == REQ_INSERT) begin
                        w_ctl.load  = 1'b1;
                        w_load_idx  = r_cnt[IW-1:0];
                        w_load_data = '{id:     r_req.volume_id,
                                        target: r_req.target_addr,
                                        stamp:  r_req.now_seconds};
                        n_cnt       = r_cnt + CW'(1);
                    end
                    n_out_data  = '{found:         r_found,
                                    found_addr:    r_faddr,
                                    dropped_count: sat5(r_drop),
                                    entries_used:  sat5(n_cnt)};
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_redirect  <= REDIRECT_MINUTES_RESET;
            r_relax     <= RELAX_STEP_MINUTES_RESET;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_we && (i_cfg_index == CFG_REDIRECT_MINUTES)) begin
                r_redirect <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_index == CFG_RELAX_STEP_MINUTES)) begin
                r_relax <= i_cfg_data[5:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_left     <= n_left;
        r_drop     <= n_drop;
        r_horizon  <= n_horizon;
        r_cutoff   <= n_cutoff;
        r_flush    <= n_flush;
        r_found    <= n_found;
        r_faddr    <= n_faddr;
        r_req      <= n_req;
        r_out_data <= n_out_data;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* tb/aging_redirect_table_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aging_redirect_table_tb - self-checking bench of the aging redirect table
// A queue-fed driver and a clocked monitor. Each transfer on the request side
// runs through a local model of the table, and each result transfer is
// checked against the oldest predicted result. Phases switch the age horizon
// and relax step while the table is idle, and both sides idle at random.
// ----------------------------------------------------------------------------
module aging_redirect_table_tb;
    import art_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int MAX_REPORTS = 10;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = CFG_REDIRECT_MINUTES;
    logic [9:0] cfg_data = '0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    t_req       in_data = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_result    out_data;

    aging_redirect_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    always begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // model of the table
    t_entry     tbl [TABLE_DEPTH];
    int         tbl_count = 0;
    logic [9:0] horizon_minutes = REDIRECT_MINUTES_RESET;
    logic [5:0] relax_minutes = RELAX_STEP_MINUTES_RESET;

    t_req       pending_requests [$];
    t_result    predicted_results [$];
    int         queued_count = 0;
    int         accepted_count = 0;
    int         mismatch_count = 0;
    longint     cycle_count = 0;
    longint     cycle_budget = 5000;

    bit         in_taken = 1'b0;
    bit         out_taken = 1'b0;
    int         in_gap = 0;
    int         out_hold = 0;
    bit         no_idle = 1'b0;

    longint      sim_now = 0;
    logic [31:0] id_pool [8];

    // Drop entries not newer than now - horizon; keep survivors in order.
    function automatic int age_table(input longint horizon, input logic [30:0] now);
        longint cutoff;
        int keep;
        int gone;
        int i;
        cutoff = longint'({33'd0, now}) - horizon * 60;
        keep = 0;
        gone = 0;
        for (i = 0; i < tbl_count; i++) begin
            if (horizon >= 0 && longint'({33'd0, tbl[i].stamp}) > cutoff) begin
                tbl[keep] = tbl[i];
                keep++;
            end else begin
                gone++;
            end
        end
        tbl_count = keep;
        return gone;
    endfunction

    function automatic t_result predict_redirect(input t_req rq);
        t_result res;
        longint horizon;
        longint step;
        int dropped;
        int i;
        res = '0;
        dropped = 0;
        case (rq.req_type)
            REQ_INSERT: begin
                horizon = longint'(horizon_minutes);
                step = (relax_minutes == 6'd0) ? 1 : longint'(relax_minutes);
                while (tbl_count >= TABLE_DEPTH) begin
                    dropped += age_table(horizon, rq.now_seconds);
                    horizon -= step;
                end
                tbl[tbl_count].id = rq.volume_id;
                tbl[tbl_count].target = rq.target_addr;
                tbl[tbl_count].stamp = rq.now_seconds;
                tbl_count++;
            end
            REQ_LOOKUP: begin
                for (i = tbl_count - 1; i >= 0 && !res.found; i--) begin
                    if (tbl[i].id == rq.volume_id) begin
                        res.found = 1'b1;
                        res.found_addr = tbl[i].target;
                    end
                end
            end
            REQ_SWEEP: begin
                dropped = age_table(longint'(horizon_minutes), rq.now_seconds);
            end
            default: begin
            end
        endcase
        res.dropped_count = (dropped > 31) ? 5'd31 : 5'(dropped);
        res.entries_used = (tbl_count > 31) ? 5'd31 : 5'(tbl_count);
        return res;
    endfunction

    // request side
    always @(negedge clk) begin : drive_requests
        logic holding;
        holding = in_valid && !in_taken;
        if (rst_n && !holding) begin
            if (in_gap > 0) begin
                in_valid <= 1'b0;
                in_gap <= in_gap - 1;
            end else if (pending_requests.size() != 0) begin
                in_valid <= 1'b1;
                in_data <= pending_requests.pop_front();
                in_gap <= no_idle ? 0 : $urandom_range(0, 15);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result side: hold stall for a drawn number of cycles after each transfer
    always @(negedge clk) begin : drive_stall
        int hold_n;
        hold_n = out_taken ? (no_idle ? 0 : $urandom_range(0, 15)) : out_hold;
        if (!rst_n || hold_n == 0) begin
            out_stall <= 1'b0;
            out_hold <= 0;
        end else begin
            out_stall <= 1'b1;
            out_hold <= hold_n - 1;
        end
    end

    always @(posedge clk) begin : watch_transfers
        t_result want;
        in_taken <= in_valid && !in_stall;
        out_taken <= out_valid && !out_stall;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (predicted_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("ERROR: result with nothing predicted: found=%0b addr=%h drop=%0d used=%0d",
                                 out_data.found, out_data.found_addr,
                                 out_data.dropped_count, out_data.entries_used);
                end else begin
                    want = predicted_results.pop_front();
                    if (out_data.found !== want.found ||
                        out_data.found_addr !== want.found_addr ||
                        out_data.dropped_count !== want.dropped_count ||
                        out_data.entries_used !== want.entries_used) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("ERROR: expected found=%0b addr=%h drop=%0d used=%0d, got found=%0b addr=%h drop=%0d used=%0d",
                                     want.found, want.found_addr, want.dropped_count,
                                     want.entries_used, out_data.found, out_data.found_addr,
                                     out_data.dropped_count, out_data.entries_used);
                    end
                end
            end
            if (in_valid && !in_stall) begin
                predicted_results.push_back(predict_redirect(in_data));
                accepted_count++;
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > cycle_budget) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic queue_req(input logic [1:0] kind, input logic [31:0] id,
                             input logic [31:0] addr, input logic [30:0] now);
        t_req rq;
        int step_eff;
        rq.req_type = kind;
        rq.volume_id = id;
        rq.target_addr = addr;
        rq.now_seconds = now;
        step_eff = (relax_minutes == 6'd0) ? 1 : int'(relax_minutes);
        // allow a full run of eviction passes for every insert
        if (kind == REQ_INSERT)
            cycle_budget += 4 * (48 + (int'(horizon_minutes) / step_eff + 3) * (TABLE_DEPTH + 2));
        else
            cycle_budget += 4 * (48 + TABLE_DEPTH + 4);
        pending_requests.push_back(rq);
        queued_count++;
    endtask

    task automatic wait_idle();
        do @(negedge clk);
        while (accepted_count != queued_count || predicted_results.size() != 0);
    endtask

    task automatic write_cfg(input logic [1:0] index, input logic [9:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (index == CFG_REDIRECT_MINUTES)
            horizon_minutes = data;
        else if (index == CFG_RELAX_STEP_MINUTES)
            relax_minutes = data[5:0];
    endtask

    task automatic run_phase(input int minutes, input int step, input int n_items,
                             input int advance, input bit calm);
        int k;
        int pick;
        int kind_draw;
        logic [1:0] kind;
        logic [31:0] id;
        logic [30:0] now;
        wait_idle();
        write_cfg(CFG_REDIRECT_MINUTES, minutes[9:0]);
        write_cfg(CFG_RELAX_STEP_MINUTES, {4'($urandom), step[5:0]});
        no_idle = calm;
        for (k = 0; k < n_items; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                now = 31'($urandom);
            end else begin
                if (pick < 8)
                    sim_now -= $urandom_range(0, advance);
                else
                    sim_now += $urandom_range(0, advance);
                if (sim_now < 0)
                    sim_now = 0;
                if (sim_now > 64'h7FFF_FFFF)
                    sim_now = $urandom_range(0, 1000);
                now = sim_now[30:0];
            end
            kind_draw = $urandom_range(0, 99);
            if (kind_draw < 45)
                kind = REQ_INSERT;
            else if (kind_draw < 80)
                kind = REQ_LOOKUP;
            else if (kind_draw < 96)
                kind = REQ_SWEEP;
            else
                kind = REQ_UNUSED;
            id = ($urandom_range(0, 9) < 7) ? id_pool[$urandom_range(0, 7)] : $urandom;
            if (kind == REQ_INSERT && $urandom_range(0, 3) == 0)
                id_pool[$urandom_range(0, 7)] = id;
            queue_req(kind, id, $urandom, now);
        end
    endtask

    initial begin
        int i;
        int minutes;
        for (i = 0; i < 8; i++)
            id_pool[i] = $urandom;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty table, extremes, duplicates, eviction, flush
        queue_req(REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0, 31'd0);
        queue_req(REQ_SWEEP, 32'h0, 32'h0, 31'd0);
        queue_req(REQ_UNUSED, 32'h1234_5678, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
        queue_req(REQ_INSERT, 32'h0, 32'h0, 31'd0);
        queue_req(REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'd100);
        queue_req(REQ_INSERT, 32'h0, 32'hA5A5_A5A5, 31'd200);
        queue_req(REQ_LOOKUP, 32'h0, 32'h0, 31'd200);
        queue_req(REQ_SWEEP, 32'h0, 32'h0, 31'd3700);
        for (i = 1; i <= 15; i++)
            queue_req(REQ_INSERT, 32'(i), 32'h5A5A_0000 | 32'(i), 31'd5000);
        // full: the first pass ages out the oldest entry
        queue_req(REQ_INSERT, 32'd16, 32'hDEAD_0016, 31'd5000);
        // full with every stamp after now: the horizon goes negative
        queue_req(REQ_INSERT, 32'd17, 32'hDEAD_0017, 31'd4000);
        queue_req(REQ_LOOKUP, 32'd16, 32'h0, 31'd4000);
        queue_req(REQ_INSERT, 32'hFFFF_FFFF, 32'h0, 31'h7FFF_FFFF);
        queue_req(REQ_LOOKUP, 32'd17, 32'h0, 31'h7FFF_FFFF);
        queue_req(REQ_UNUSED, 32'h0, 32'h0, 31'd0);

        sim_now = 10000;
        run_phase(60, 10, 300, 400, 1'b0);
        run_phase(0, 1, 150, 60, 1'b1);
        sim_now = 64'h7FFF_FFFF - 400000;
        run_phase(1023, 60, 200, 4000, 1'b0);
        run_phase(1023, 1, 40, 8000, 1'b0);
        run_phase(5, 0, 150, 60, 1'b0);
        run_phase(200, 63, 150, 1500, 1'b1);
        run_phase(1, 1, 150, 30, 1'b0);
        for (i = 0; i < 6; i++) begin
            minutes = $urandom_range(0, 300);
            run_phase(minutes, $urandom_range(1, 60), 150, minutes * 60 / 8 + 30,
                      $urandom_range(0, 3) == 0);
        end

        wait_idle();
        repeat (4 * TABLE_DEPTH + 40) @(posedge clk);
        if (mismatch_count == 0 && predicted_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
